/* rtl/lpwbb_pkg.sv */
// Shared types and constants of the LRU pool with byte budget.
package lpwbb_pkg;

    localparam int NumEntries = 16;
    localparam int SlotW      = $clog2(NumEntries);
    localparam int CountW     = $clog2(NumEntries + 1);
    localparam int DimW       = 15;
    localparam int FmtW       = 8;
    localparam int BppW       = 5;
    localparam int FootW      = 36;
    localparam int TotalW     = 48;
    localparam int CfgIdxW    = 2;
    localparam int CfgDataW   = 48;

    localparam logic [CfgIdxW-1:0] CfgEntryLimit = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgByteBudget = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgMemoryless = 2'd2;
    localparam logic [CfgIdxW-1:0] CfgDepthBpp   = 2'd3;

    localparam logic OpAcquire = 1'b0;
    localparam logic OpClear   = 1'b1;

    localparam logic [FootW-1:0]  FootMax  = {FootW{1'b1}};
    localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input beat
        logic clear;     // empty the pool
        logic search;    // register tag match result
        logic mul1;      // first product stage
        logic mul2;      // second product stage
        logic promote;   // hit: update ranks
        logic insert;    // miss: write new entry
        logic evict;     // drop least recent entry
        logic fin;       // capture result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_clear;
        logic hit;
        logic full;
        logic over;
    } t_status;

endpackage

/* rtl/lpwbb_datapath.sv */
// Datapath: entry store, tag match, footprint multiply, byte total.
module lpwbb_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lpwbb_pkg::t_cmd                   i_cmd,
    output lpwbb_pkg::t_status                o_status,
    input  logic                              i_op,
    input  logic [lpwbb_pkg::DimW-1:0]        i_req_width,
    input  logic [lpwbb_pkg::DimW-1:0]        i_req_height,
    input  logic [lpwbb_pkg::FmtW-1:0]        i_color_format,
    input  logic                              i_msaa_on,
    input  logic [lpwbb_pkg::BppW-1:0]        i_color_bytes_per_pixel,
    input  logic [4:0]                        i_entry_limit,
    input  logic [lpwbb_pkg::TotalW-1:0]      i_byte_budget,
    input  logic                              i_memoryless_mode,
    input  logic [4:0]                        i_depth_bpp,
    output logic                              o_hit,
    output logic [lpwbb_pkg::SlotW-1:0]       o_slot,
    output logic [4:0]                        o_evicted_count,
    output logic [4:0]                        o_entry_count,
    output logic [lpwbb_pkg::TotalW-1:0]      o_total_bytes,
    output logic [lpwbb_pkg::FootW-1:0]       o_footprint
);
    localparam int N  = lpwbb_pkg::NumEntries;
    localparam int SW = lpwbb_pkg::SlotW;
    localparam int CW = lpwbb_pkg::CountW;

    logic                           r_op, r_msaa;
    logic [lpwbb_pkg::DimW-1:0]     r_w, r_h;
    logic [lpwbb_pkg::FmtW-1:0]     r_fmt;
    logic [lpwbb_pkg::BppW-1:0]     r_cbpp;

    logic [N-1:0]                   r_valid;
    logic [lpwbb_pkg::DimW-1:0]     r_ew [N];
    logic [lpwbb_pkg::DimW-1:0]     r_eh [N];
    logic [lpwbb_pkg::FmtW-1:0]     r_ef [N];
    logic                           r_em [N];
    logic [lpwbb_pkg::FootW-1:0]    r_eb [N];
    logic [SW-1:0]                  r_rank [N];
    logic [lpwbb_pkg::TotalW-1:0]   r_total;
    logic [CW-1:0]                  r_held;

    logic                           r_hit;
    logic [SW-1:0]                  r_slot;
    logic [CW-1:0]                  r_evicted;
    logic [29:0]                    r_px;
    logic [38:0]                    r_foot_raw;
    logic                           r_zero;

    logic [N-1:0]                   match;
    logic [SW-1:0]                  match_idx, free_idx, old_idx;
    logic [N-1:0]                   old_hit;
    logic [CW-1:0]                  limit;
    logic [7:0]                     bpp_sum;
    logic [lpwbb_pkg::FootW-1:0]    foot_sat;
    logic [lpwbb_pkg::TotalW:0]     add_sum;

    always_comb begin
        match_idx = '0;
        free_idx  = '0;
        old_idx   = '0;
        for (int i = N - 1; i >= 0; i--) begin
            match[i]   = r_valid[i] && r_ew[i] == r_w && r_eh[i] == r_h &&
                         r_ef[i] == r_fmt && r_em[i] == r_msaa;
            old_hit[i] = r_valid[i] && ({1'b0, r_rank[i]} + 1'b1) == r_held;
            if (match[i])   match_idx = SW'(i);
            if (!r_valid[i]) free_idx = SW'(i);
            if (old_hit[i]) old_idx = SW'(i);
        end
    end

    always_comb begin
        if (i_entry_limit == 5'd0) limit = CW'(1);
        else if (32'(i_entry_limit) > N) limit = CW'(N);
        else limit = CW'(i_entry_limit);
    end

    // depth*4 + color*4 with MSAA, depth alone without
    assign bpp_sum = r_msaa ? (8'(i_depth_bpp) << 2) + (8'(r_cbpp) << 2)
                            : 8'(i_depth_bpp);
    assign foot_sat = r_zero ? '0 :
                      (r_foot_raw > 39'(lpwbb_pkg::FootMax)) ? lpwbb_pkg::FootMax
                                                             : r_foot_raw[35:0];
    assign add_sum = {1'b0, r_total} + 49'(foot_sat);

    assign o_status.is_clear = r_op;
    assign o_status.hit      = r_hit;
    assign o_status.full     = r_held >= CW'(N);
    assign o_status.over     = r_held > CW'(1) &&
                               (r_held > limit || r_total > i_byte_budget);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_w    <= i_req_width;
            r_h    <= i_req_height;
            r_fmt  <= i_color_format;
            r_msaa <= i_msaa_on;
            r_cbpp <= i_color_bytes_per_pixel;
        end
        if (i_cmd.search) begin
            r_hit  <= |match;
            r_slot <= match_idx;
        end
        if (i_cmd.mul1) begin
            r_px   <= 30'(r_w) * 30'(r_h);
            r_zero <= i_memoryless_mode || r_w == '0 || r_h == '0;
        end
        if (i_cmd.mul2) r_foot_raw <= 39'(r_px) * 39'(bpp_sum);
        if (i_cmd.insert) begin
            r_slot       <= free_idx;
            r_ew[free_idx] <= r_w;
            r_eh[free_idx] <= r_h;
            r_ef[free_idx] <= r_fmt;
            r_em[free_idx] <= r_msaa;
            r_eb[free_idx] <= foot_sat;
        end
        for (int i = 0; i < N; i++) begin
            if (i_cmd.promote && r_valid[i] && r_rank[i] < r_rank[r_slot])
                r_rank[i] <= r_rank[i] + 1'b1;
            if (i_cmd.insert && r_valid[i]) r_rank[i] <= r_rank[i] + 1'b1;
        end
        if (i_cmd.promote) r_rank[r_slot] <= '0;
        if (i_cmd.insert)  r_rank[free_idx] <= '0;
        if (i_cmd.fin) begin
            o_hit           <= !r_op && r_hit;
            o_slot          <= r_op ? '0 : r_slot;
            o_evicted_count <= 5'(r_evicted);
            o_entry_count   <= 5'(r_held);
            o_total_bytes   <= r_total;
            o_footprint     <= r_op ? '0 : r_hit ? r_eb[r_slot] : foot_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_total   <= '0;
            r_held    <= '0;
            r_evicted <= '0;
        end else begin
            if (i_cmd.load) r_evicted <= '0;
            if (i_cmd.clear) begin
                r_valid <= '0;
                r_total <= '0;
                r_held  <= '0;
            end else if (i_cmd.evict) begin
                r_valid[old_idx] <= 1'b0;
                r_total   <= (r_total >= 48'(r_eb[old_idx])) ? r_total - 48'(r_eb[old_idx])
                                                             : '0;
                r_held    <= r_held - 1'b1;
                r_evicted <= r_evicted + 1'b1;
            end else if (i_cmd.insert) begin
                r_valid[free_idx] <= 1'b1;
                r_held  <= r_held + 1'b1;
                r_total <= add_sum[lpwbb_pkg::TotalW] ? lpwbb_pkg::TotalMax
                                                      : add_sum[lpwbb_pkg::TotalW-1:0];
            end
        end
    end
endmodule

/* rtl/lpwbb_ctrl.sv */
// Controller: sequences search, multiply, insert and eviction walk.
module lpwbb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  lpwbb_pkg::t_status i_status,
    output lpwbb_pkg::t_cmd    o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_SEARCH, S_DECIDE, S_MUL, S_INSERT, S_EVICT, S_FIN
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    assign o_in_ready  = r_state == S_IDLE && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = i_in_valid && o_in_ready;
        o_cmd.search = r_state == S_SEARCH;
        o_cmd.mul1   = r_state == S_SEARCH;
        o_cmd.clear  = r_state == S_DECIDE && i_status.is_clear;
        o_cmd.promote = r_state == S_DECIDE && !i_status.is_clear && i_status.hit;
        o_cmd.mul2   = r_state == S_MUL;
        o_cmd.evict  = (r_state == S_MUL && i_status.full) ||
                       (r_state == S_EVICT && i_status.over);
        o_cmd.insert = r_state == S_INSERT;
        o_cmd.fin    = r_state == S_FIN;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE:   if (o_cmd.load) r_state <= S_SEARCH;
                S_SEARCH: r_state <= S_DECIDE;
                S_DECIDE: r_state <= (i_status.is_clear || i_status.hit) ? S_FIN : S_MUL;
                S_MUL:    r_state <= S_INSERT;
                S_INSERT: r_state <= S_EVICT;
                S_EVICT:  if (!i_status.over) r_state <= S_FIN;
                S_FIN: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default:  r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* rtl/lru_pool_with_byte_budget.sv */
// Top level of the LRU attachment pool with entry and byte limits.
//   channel | direction | handshake                  | payload
//   in      | input     | i_in_valid / o_in_ready    | op, key, color bpp
//   out     | output    | o_out_valid / i_out_ready  | hit, slot, counts, bytes
//   cfg     | input     | i_cfg_valid / o_cfg_ready  | index, data
// One item at a time: a hit or clear steps through search, decide and finish;
// a miss adds multiply, insert and an eviction state held while over a limit;
// the eviction that frees a slot in a full pool overlaps the second multiply stage.
// Synchronous active-low reset empties the pool and loads register defaults.
// A result holds in the output register until taken; the next item is taken
// in the same cycle the previous result leaves.
module lru_pool_with_byte_budget (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_op,
    input  logic [lpwbb_pkg::DimW-1:0]        i_req_width,
    input  logic [lpwbb_pkg::DimW-1:0]        i_req_height,
    input  logic [lpwbb_pkg::FmtW-1:0]        i_color_format,
    input  logic                              i_msaa_on,
    input  logic [lpwbb_pkg::BppW-1:0]        i_color_bytes_per_pixel,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_hit,
    output logic [lpwbb_pkg::SlotW-1:0]       o_slot,
    output logic [4:0]                        o_evicted_count,
    output logic [4:0]                        o_entry_count,
    output logic [lpwbb_pkg::TotalW-1:0]      o_total_bytes,
    output logic [lpwbb_pkg::FootW-1:0]       o_footprint,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lpwbb_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  logic [lpwbb_pkg::CfgDataW-1:0]    i_cfg_data
);
    lpwbb_pkg::t_cmd    cmd;
    lpwbb_pkg::t_status status;

    logic [4:0]                   r_entry_limit;
    logic [lpwbb_pkg::TotalW-1:0] r_byte_budget;
    logic                         r_memoryless;
    logic [4:0]                   r_depth_bpp;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_limit <= 5'd16;
            r_byte_budget <= 48'd67108864;
            r_memoryless  <= 1'b0;
            r_depth_bpp   <= 5'd4;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lpwbb_pkg::CfgEntryLimit: r_entry_limit <= i_cfg_data[4:0];
                lpwbb_pkg::CfgByteBudget: r_byte_budget <= i_cfg_data;
                lpwbb_pkg::CfgMemoryless: r_memoryless  <= i_cfg_data[0];
                lpwbb_pkg::CfgDepthBpp:   r_depth_bpp   <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    lpwbb_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready,
        .i_status(status), .o_cmd(cmd)
    );

    lpwbb_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_status(status),
        .i_op, .i_req_width, .i_req_height, .i_color_format, .i_msaa_on,
        .i_color_bytes_per_pixel,
        .i_entry_limit(r_entry_limit), .i_byte_budget(r_byte_budget),
        .i_memoryless_mode(r_memoryless), .i_depth_bpp(r_depth_bpp),
        .o_hit, .o_slot, .o_evicted_count, .o_entry_count, .o_total_bytes, .o_footprint
    );

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_entry_count <= 5'(lpwbb_pkg::NumEntries))
        else $error("entry count above capacity");
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hit) |-> o_evicted_count == 5'd0)
        else $error("eviction on hit");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item accepted while busy");
`endif
endmodule

/* verif/lru_pool_with_byte_budget_chk.sv */
// Checker for the LRU attachment pool: tracks register writes and input beats and checks results.
module lru_pool_with_byte_budget_chk (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic                           i_op,
    input  logic [lpwbb_pkg::DimW-1:0]     i_req_width,
    input  logic [lpwbb_pkg::DimW-1:0]     i_req_height,
    input  logic [lpwbb_pkg::FmtW-1:0]     i_color_format,
    input  logic                           i_msaa_on,
    input  logic [lpwbb_pkg::BppW-1:0]     i_color_bytes_per_pixel,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic                           i_hit,
    input  logic [lpwbb_pkg::SlotW-1:0]    i_slot,
    input  logic [4:0]                     i_evicted_count,
    input  logic [4:0]                     i_entry_count,
    input  logic [lpwbb_pkg::TotalW-1:0]   i_total_bytes,
    input  logic [lpwbb_pkg::FootW-1:0]    i_footprint,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [lpwbb_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [lpwbb_pkg::CfgDataW-1:0] i_cfg_data,
    output int                             o_errors,
    output int                             o_pending,
    output int                             o_results,
    output int                             o_hits,
    output int                             o_evictions
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NumEntries = lpwbb_pkg::NumEntries;
    localparam int DimW       = lpwbb_pkg::DimW;
    localparam int FmtW       = lpwbb_pkg::FmtW;
    localparam int BppW       = lpwbb_pkg::BppW;
    localparam int SlotW      = lpwbb_pkg::SlotW;
    localparam int FootW      = lpwbb_pkg::FootW;
    localparam int TotalW     = lpwbb_pkg::TotalW;

    typedef struct packed {
        logic              hit;
        logic [SlotW-1:0]  slot;
        logic [4:0]        evicted;
        logic [4:0]        count;
        logic [TotalW-1:0] total;
        logic [FootW-1:0]  foot;
    } t_pool_result;

    t_pool_result pool_results[$];

    logic [4:0]        lim_r;
    logic [TotalW-1:0] budget_r;
    logic              memless_r;
    logic [4:0]        dbpp_r;

    logic              e_valid [NumEntries];
    logic [DimW-1:0]   e_w     [NumEntries];
    logic [DimW-1:0]   e_h     [NumEntries];
    logic [FmtW-1:0]   e_fmt   [NumEntries];
    logic              e_msaa  [NumEntries];
    logic [FootW-1:0]  e_bytes [NumEntries];
    int unsigned       e_rank  [NumEntries];
    logic [TotalW-1:0] held_bytes;
    int unsigned       held;

    function automatic logic [FootW-1:0] attach_bytes(logic [DimW-1:0] w, logic [DimW-1:0] h,
                                                     logic msaa, logic [BppW-1:0] cbpp);
        logic [63:0] px, sum;
        if (memless_r || w == 0 || h == 0) return '0;
        px  = 64'(w) * 64'(h);
        sum = px * dbpp_r * (msaa ? 64'd4 : 64'd1) + (msaa ? px * cbpp * 64'd4 : 64'd0);
        return (sum > 64'(lpwbb_pkg::FootMax)) ? lpwbb_pkg::FootMax : sum[FootW-1:0];
    endfunction

    task automatic drop_oldest();
        for (int i = 0; i < NumEntries; i++) begin
            if (e_valid[i] && e_rank[i] + 1 == held) begin
                held_bytes = (held_bytes >= 48'(e_bytes[i])) ? held_bytes - 48'(e_bytes[i]) : '0;
                e_valid[i] = 1'b0;
                held--;
                return;
            end
        end
    endtask

    task automatic predict_acquire(logic op, logic [DimW-1:0] w, logic [DimW-1:0] h,
                                   logic [FmtW-1:0] fmt, logic msaa, logic [BppW-1:0] cbpp);
        t_pool_result r;
        int           s;
        int unsigned  lim, rk;
        logic [48:0]  sum;
        r = '0;
        s = -1;
        if (op == lpwbb_pkg::OpClear) begin
            for (int i = 0; i < NumEntries; i++) e_valid[i] = 1'b0;
            held_bytes = '0;
            held = 0;
            s = 0;
        end else begin
            for (int i = 0; i < NumEntries; i++) begin
                if (s < 0 && e_valid[i] && e_w[i] == w && e_h[i] == h && e_fmt[i] == fmt
                    && e_msaa[i] == msaa) s = i;
            end
            if (s >= 0) begin
                rk = e_rank[s];
                for (int i = 0; i < NumEntries; i++)
                    if (e_valid[i] && e_rank[i] < rk) e_rank[i]++;
                e_rank[s] = 0;
                r.hit = 1'b1;
                r.foot = e_bytes[s];
            end else begin
                if (held >= NumEntries) begin
                    drop_oldest();
                    r.evicted++;
                end
                for (int i = 0; i < NumEntries; i++)
                    if (s < 0 && !e_valid[i]) s = i;
                for (int i = 0; i < NumEntries; i++)
                    if (e_valid[i]) e_rank[i]++;
                r.foot = attach_bytes(w, h, msaa, cbpp);
                e_valid[s] = 1'b1;
                e_w[s] = w;
                e_h[s] = h;
                e_fmt[s] = fmt;
                e_msaa[s] = msaa;
                e_bytes[s] = r.foot;
                e_rank[s] = 0;
                held++;
                sum = 49'(held_bytes) + 49'(r.foot);
                held_bytes = (sum > 49'(lpwbb_pkg::TotalMax)) ? lpwbb_pkg::TotalMax
                                                              : sum[TotalW-1:0];
                lim = (lim_r > NumEntries) ? NumEntries : lim_r;
                while (held > 1 && (held > lim || held_bytes > budget_r)) begin
                    drop_oldest();
                    r.evicted++;
                end
                o_evictions += r.evicted;
            end
        end
        r.slot = s[SlotW-1:0];
        r.count = 5'(held);
        r.total = held_bytes;
        pool_results.push_back(r);
    endtask

    assign o_pending = pool_results.size();

    always @(posedge i_clk) begin
        t_pool_result want, got;
        if (!i_rst_n) begin
            lim_r = 5'd16;
            budget_r = 48'd67108864;
            memless_r = 1'b0;
            dbpp_r = 5'd4;
            for (int i = 0; i < NumEntries; i++) e_valid[i] = 1'b0;
            held_bytes = '0;
            held = 0;
            pool_results.delete();
            o_errors <= 0;
            o_results <= 0;
            o_hits <= 0;
            o_evictions = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    lpwbb_pkg::CfgEntryLimit: lim_r = i_cfg_data[4:0];
                    lpwbb_pkg::CfgByteBudget: budget_r = i_cfg_data[TotalW-1:0];
                    lpwbb_pkg::CfgMemoryless: memless_r = i_cfg_data[0];
                    lpwbb_pkg::CfgDepthBpp:   dbpp_r = i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got = '{i_hit, i_slot, i_evicted_count, i_entry_count, i_total_bytes,
                        i_footprint};
                o_results <= o_results + 1;
                if (i_hit) o_hits <= o_hits + 1;
                if (pool_results.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result %p", got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = pool_results.pop_front();
                    if (got !== want) begin
                        if (o_errors < 10)
                            $display("mismatch at %0t: expected %p, got %p", $realtime, want, got);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                predict_acquire(i_op, i_req_width, i_req_height, i_color_format, i_msaa_on,
                                i_color_bytes_per_pixel);
        end
    end
endmodule

/* verif/lru_pool_with_byte_budget_tb.sv */
// Testbench top for the LRU attachment pool: stimulus, register phases and verdict.
module lru_pool_with_byte_budget_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   IdleLimit = 5000;
    localparam int   DimW      = lpwbb_pkg::DimW;
    localparam int   FmtW      = lpwbb_pkg::FmtW;
    localparam int   BppW      = lpwbb_pkg::BppW;
    localparam int   CfgIdxW   = lpwbb_pkg::CfgIdxW;
    localparam int   CfgDataW  = lpwbb_pkg::CfgDataW;

    logic                i_clk, i_rst_n;
    logic                i_in_valid, o_in_ready;
    logic                i_op;
    logic [DimW-1:0]     i_req_width, i_req_height;
    logic [FmtW-1:0]     i_color_format;
    logic                i_msaa_on;
    logic [BppW-1:0]     i_color_bytes_per_pixel;
    logic                o_out_valid, i_out_ready;
    logic                o_hit;
    logic [lpwbb_pkg::SlotW-1:0]  o_slot;
    logic [4:0]          o_evicted_count, o_entry_count;
    logic [lpwbb_pkg::TotalW-1:0] o_total_bytes;
    logic [lpwbb_pkg::FootW-1:0]  o_footprint;
    logic                i_cfg_valid, o_cfg_ready;
    logic [CfgIdxW-1:0]  i_cfg_index;
    logic [CfgDataW-1:0] i_cfg_data;
    int                  errors, pending, results, hits, evictions;
    int                  send_idle, recv_stall, idle_cycles, items_sent;
    logic [DimW-1:0]     key_w [8];
    logic [DimW-1:0]     key_h [8];
    logic [FmtW-1:0]     key_f [8];

    lru_pool_with_byte_budget dut (.*);

    lru_pool_with_byte_budget_chk chk (
        .i_clk, .i_rst_n,
        .i_in_valid, .i_in_ready(o_in_ready), .i_op, .i_req_width, .i_req_height,
        .i_color_format, .i_msaa_on, .i_color_bytes_per_pixel,
        .i_out_valid(o_out_valid), .i_out_ready, .i_hit(o_hit), .i_slot(o_slot),
        .i_evicted_count(o_evicted_count), .i_entry_count(o_entry_count),
        .i_total_bytes(o_total_bytes), .i_footprint(o_footprint),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_errors(errors), .o_pending(pending), .o_results(results), .o_hits(hits),
        .o_evictions(evictions)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // stall the result side at the phase's rate
    always @(posedge i_clk)
        i_out_ready <= ($urandom_range(99) >= recv_stall);

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("[lru_pool_with_byte_budget] ERROR");
            $finish;
        end
    end

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    // valid stays up after the accepting edge only for the same time step
    task automatic send_item(logic op, logic [DimW-1:0] w, logic [DimW-1:0] h,
                             logic [FmtW-1:0] f, logic m, logic [BppW-1:0] b);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_req_width <= w;
        i_req_height <= h;
        i_color_format <= f;
        i_msaa_on <= m;
        i_color_bytes_per_pixel <= b;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    // mostly acquires on a small key set so hits and evictions both happen
    task automatic random_item();
        int k;
        k = $urandom_range(7);
        case ($urandom_range(9))
            0: send_item(($urandom_range(15) == 0) ? lpwbb_pkg::OpClear : lpwbb_pkg::OpAcquire,
                         DimW'($urandom), DimW'($urandom), FmtW'($urandom), 1'($urandom),
                         BppW'($urandom));
            1: send_item(lpwbb_pkg::OpAcquire, DimW'($urandom_range(16384)),
                         DimW'($urandom_range(16384)), FmtW'($urandom), 1'($urandom),
                         BppW'($urandom_range(1, 16)));
            default: send_item(lpwbb_pkg::OpAcquire, key_w[k], key_h[k], key_f[k], k[0],
                               BppW'($urandom_range(1, 16)));
        endcase
    endtask

    task automatic random_keys(int big);
        for (int i = 0; i < 8; i++) begin
            key_w[i] = big ? DimW'($urandom_range(16384)) : DimW'($urandom_range(64));
            key_h[i] = big ? DimW'($urandom_range(16384)) : DimW'($urandom_range(64));
            key_f[i] = FmtW'($urandom);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_op = lpwbb_pkg::OpAcquire;
        i_req_width = '0;
        i_req_height = '0;
        i_color_format = '0;
        i_msaa_on = 1'b0;
        i_color_bytes_per_pixel = 5'd1;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = lpwbb_pkg::CfgEntryLimit;
        i_cfg_data = '0;
        send_idle = 0;
        recv_stall = 0;
        items_sent = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, hits, zero sizes, oversized footprint, clear
        send_item(lpwbb_pkg::OpAcquire, 15'd0, 15'd100, 8'd0, 1'b0, 5'd1);
        send_item(lpwbb_pkg::OpAcquire, 15'd100, 15'd0, 8'd255, 1'b1, 5'd16);
        send_item(lpwbb_pkg::OpAcquire, 15'd16384, 15'd16384, 8'd7, 1'b1, 5'd16);
        send_item(lpwbb_pkg::OpAcquire, 15'h7FFF, 15'h7FFF, 8'hFF, 1'b1, 5'h1F);
        send_item(lpwbb_pkg::OpAcquire, 15'd0, 15'd100, 8'd0, 1'b0, 5'd1);
        send_item(lpwbb_pkg::OpClear, 15'h7FFF, 15'h7FFF, 8'hFF, 1'b1, 5'h1F);
        for (int i = 0; i < 18; i++)
            send_item(lpwbb_pkg::OpAcquire, 15'(i + 1), 15'd2, 8'(i), 1'b0, 5'd4);
        send_item(lpwbb_pkg::OpAcquire, 15'd18, 15'd2, 8'd17, 1'b0, 5'd4);
        settle();
        // limit at zero and above the pool size, tiny budget
        write_reg(lpwbb_pkg::CfgEntryLimit, 48'd0);
        send_item(lpwbb_pkg::OpAcquire, 15'd3, 15'd3, 8'd1, 1'b0, 5'd2);
        send_item(lpwbb_pkg::OpAcquire, 15'd4, 15'd3, 8'd1, 1'b0, 5'd2);
        settle();
        write_reg(lpwbb_pkg::CfgEntryLimit, 48'h1F);
        write_reg(lpwbb_pkg::CfgByteBudget, 48'd1);
        write_reg(lpwbb_pkg::CfgDepthBpp, 48'h1F);
        send_item(lpwbb_pkg::OpAcquire, 15'd5, 15'd5, 8'd1, 1'b1, 5'd3);
        send_item(lpwbb_pkg::OpAcquire, 15'd6, 15'd5, 8'd1, 1'b1, 5'd3);
        settle();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 45; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 45; end
                default: begin send_idle = 11; recv_stall = 11; end
            endcase
            case (ph)
                0: write_reg(lpwbb_pkg::CfgByteBudget, lpwbb_pkg::TotalMax);
                1: write_reg(lpwbb_pkg::CfgEntryLimit, 48'd1);
                2: write_reg(lpwbb_pkg::CfgMemoryless, 48'd1);
                3: write_reg(lpwbb_pkg::CfgByteBudget, 48'd20000);
                4: write_reg(lpwbb_pkg::CfgMemoryless, 48'd0);
                5: write_reg(lpwbb_pkg::CfgEntryLimit, 48'($urandom_range(2, 16)));
                6: write_reg(lpwbb_pkg::CfgDepthBpp, 48'd1);
                default: write_reg(lpwbb_pkg::CfgByteBudget, 48'd67108864);
            endcase
            write_reg(lpwbb_pkg::CfgDepthBpp, 48'($urandom_range(1, 16)));
            random_keys(ph == 7);
            for (int n = 0; n < 150; n++) random_item();
            settle();
        end

        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        $display("sent %0d items over 8 register settings and 4 flow-control mixes", items_sent);
        $display("results %0d, hits %0d, entries evicted %0d", results, hits, evictions);
        if (errors == 0)
            $display("[lru_pool_with_byte_budget] OK");
        else
            $display("[lru_pool_with_byte_budget] ERROR");
        $finish;
    end
endmodule

/* files.f */
rtl/lpwbb_pkg.sv
rtl/lpwbb_datapath.sv
rtl/lpwbb_ctrl.sv
rtl/lru_pool_with_byte_budget.sv
verif/lru_pool_with_byte_budget_chk.sv
verif/lru_pool_with_byte_budget_tb.sv
